### sv/gmtc_pkg.sv
// Shared types, constants and register map of the generator/mains transfer controller.
package gmtc_pkg;

  // Fixed widths of the sample fields and the state counters.
  localparam int unsigned VOLT_W    = 16;
  localparam int unsigned CNT_W     = 8;
  localparam int unsigned CHANNELS  = 3;
  localparam int unsigned RELAY_W   = 5;
  localparam int unsigned CODE_W    = 4;
  localparam int unsigned EVENT_W   = 3;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned APB_AW    = 5;
  localparam int unsigned REG_IDX_W = 3;

  // Default length of the sampling window in ticks.
  localparam int unsigned WINDOW_TICKS_DEF = 10;

  // Low-sample counters stop here.
  localparam logic [CNT_W-1:0] LOW_SAT = 8'hFF;

  // Relay bit positions.
  localparam int unsigned RLY_INV    = 0;
  localparam int unsigned RLY_STOP   = 1;
  localparam int unsigned RLY_CHG    = 2;
  localparam int unsigned RLY_START  = 3;
  localparam int unsigned RLY_CHANGE = 4;

  // Condition codes.
  localparam logic [CODE_W-1:0] CODE_GEN_RUNNING = 4'd0;
  localparam logic [CODE_W-1:0] CODE_GEN_STARTING = 4'd1;
  localparam logic [CODE_W-1:0] CODE_START_FAILED = 4'd2;
  localparam logic [CODE_W-1:0] CODE_GEN_OK       = 4'd3;
  localparam logic [CODE_W-1:0] CODE_GEN_LOW      = 4'd4;
  localparam logic [CODE_W-1:0] CODE_MAINS_OK     = 4'd5;
  localparam logic [CODE_W-1:0] CODE_MAINS_LOW    = 4'd6;
  localparam logic [CODE_W-1:0] CODE_GEN_OFF      = 4'd7;
  localparam logic [CODE_W-1:0] CODE_GEN_STILL_ON = 4'd8;
  localparam logic [CODE_W-1:0] CODE_NONE         = 4'd9;

  // Events, selected by battery*4 + mains*2 + generator high bits.
  typedef enum logic [EVENT_W-1:0] {
    EV_ALL_LOW    = 3'd0,
    EV_GEN_ONLY   = 3'd1,
    EV_MAINS_ONLY = 3'd2,
    EV_MAINS_GEN  = 3'd3,
    EV_BAT_ONLY   = 3'd4,
    EV_BAT_GEN    = 3'd5,
    EV_BAT_MAINS  = 3'd6,
    EV_ALL_HIGH   = 3'd7
  } gmtc_event_e;

  // Configuration register indexes.
  typedef enum logic [REG_IDX_W-1:0] {
    REG_LOW_THRESHOLD   = 3'd0,
    REG_TRANSIT_COUNT   = 3'd1,
    REG_GEN_OK_THR      = 3'd2,
    REG_MAINS_OK_THR    = 3'd3,
    REG_GEN_OFF_THR     = 3'd4,
    REG_START_PERIOD    = 3'd5,
    REG_MAX_ATTEMPTS    = 3'd6,
    REG_SETTLE_POLLS    = 3'd7
  } gmtc_reg_e;

  typedef struct packed {
    logic [VOLT_W-1:0] low_threshold;
    logic [CNT_W-1:0]  transit_count;
    logic [VOLT_W-1:0] gen_ok_threshold;
    logic [VOLT_W-1:0] mains_ok_threshold;
    logic [VOLT_W-1:0] gen_off_threshold;
    logic [CNT_W-1:0]  start_pulse_period;
    logic [CNT_W-1:0]  max_start_attempts;
    logic [CNT_W-1:0]  settle_polls;
  } gmtc_cfg_t;

  // Configuration port activity seen by the datapath.
  typedef struct packed {
    logic access;          // a write access phase is on the port now
    logic period_written;  // the start pulse period was written last cycle
  } gmtc_cfg_evt_t;

  typedef struct packed {
    logic              mode;
    logic [VOLT_W-1:0] battery_voltage;
    logic [VOLT_W-1:0] mains_voltage;
    logic [VOLT_W-1:0] generator_voltage;
    logic              auto_request;
  } gmtc_item_t;

  typedef struct packed {
    logic [CNT_W-1:0]                window_ticks;
    logic [CHANNELS-1:0][CNT_W-1:0]  low_counts;
    logic [CNT_W-1:0]                start_count;
    logic [CNT_W-1:0]                pulse_mod;     // start_count modulo pulse period
    logic                            starter_phase;
    logic [CNT_W-1:0]                settle_count;
    logic                            auto_flag;
    logic [RELAY_W-1:0]              relay_bits;
    logic [EVENT_W-1:0]              event_index;
    logic [CODE_W-1:0]               condition_code;
    logic                            start_allowed;
    logic                            stop_allowed;
  } gmtc_state_t;

  typedef struct packed {
    logic               inverter_relay;
    logic               stop_relay;
    logic               charge_enable;
    logic               starter_drive;
    logic               changeover_relay;
    logic [EVENT_W-1:0] event_index;
    logic [CODE_W-1:0]  condition_code;
    logic               start_allowed;
    logic               stop_allowed;
    logic               auto_start;
    logic               fast_blink;
  } gmtc_result_t;

endpackage

### sv/gmtc_in_if.sv
// Request channel carrying one sample tick or mode request.
interface gmtc_in_if;
  import gmtc_pkg::*;

  logic              valid;
  logic              ready;
  logic              mode;
  logic [VOLT_W-1:0] battery_voltage;
  logic [VOLT_W-1:0] mains_voltage;
  logic [VOLT_W-1:0] generator_voltage;
  logic              auto_request;

  modport source (
    output valid, mode, battery_voltage, mains_voltage, generator_voltage, auto_request,
    input  ready
  );

  modport sink (
    input  valid, mode, battery_voltage, mains_voltage, generator_voltage, auto_request,
    output ready
  );
endinterface

### sv/gmtc_out_if.sv
// Result channel carrying relay states and status after each request.
interface gmtc_out_if;
  import gmtc_pkg::*;

  logic               valid;
  logic               ready;
  logic               inverter_relay;
  logic               stop_relay;
  logic               charge_enable;
  logic               starter_drive;
  logic               changeover_relay;
  logic [EVENT_W-1:0] event_index;
  logic [CODE_W-1:0]  condition_code;
  logic               start_allowed;
  logic               stop_allowed;
  logic               auto_start;
  logic               fast_blink;

  modport source (
    output valid, inverter_relay, stop_relay, charge_enable, starter_drive,
           changeover_relay, event_index, condition_code, start_allowed,
           stop_allowed, auto_start, fast_blink,
    input  ready
  );

  modport sink (
    input  valid, inverter_relay, stop_relay, charge_enable, starter_drive,
           changeover_relay, event_index, condition_code, start_allowed,
           stop_allowed, auto_start, fast_blink,
    output ready
  );
endinterface

### sv/gmtc_cfg_regs.sv
// APB configuration register file of the transfer controller.
module gmtc_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gmtc_pkg::APB_AW-1:0] paddr,
  input  logic [gmtc_pkg::APB_DW-1:0] pwdata,
  output logic [gmtc_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output gmtc_pkg::gmtc_cfg_t         cfg_o,
  output gmtc_pkg::gmtc_cfg_evt_t     evt_o
);
  import gmtc_pkg::*;

  gmtc_cfg_t  cfg_q;
  logic       per_wr_q;
  logic       wr_en;
  gmtc_reg_e  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = gmtc_reg_e'(paddr[APB_AW-1:2]);

  // Register writes; a period write is flagged for the modulo resync.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_threshold      <= 16'd1200;
      cfg_q.transit_count      <= 8'd5;
      cfg_q.gen_ok_threshold   <= 16'd20000;
      cfg_q.mains_ok_threshold <= 16'd20000;
      cfg_q.gen_off_threshold  <= 16'd5000;
      cfg_q.start_pulse_period <= 8'd2;
      cfg_q.max_start_attempts <= 8'd6;
      cfg_q.settle_polls       <= 8'd5;
      per_wr_q                 <= 1'b0;
    end else begin
      per_wr_q <= wr_en && (reg_idx == REG_START_PERIOD);
      if (wr_en) begin
        case (reg_idx)
          REG_LOW_THRESHOLD: cfg_q.low_threshold      <= pwdata[VOLT_W-1:0];
          REG_TRANSIT_COUNT: cfg_q.transit_count      <= pwdata[CNT_W-1:0];
          REG_GEN_OK_THR:    cfg_q.gen_ok_threshold   <= pwdata[VOLT_W-1:0];
          REG_MAINS_OK_THR:  cfg_q.mains_ok_threshold <= pwdata[VOLT_W-1:0];
          REG_GEN_OFF_THR:   cfg_q.gen_off_threshold  <= pwdata[VOLT_W-1:0];
          REG_START_PERIOD:  cfg_q.start_pulse_period <= pwdata[CNT_W-1:0];
          REG_MAX_ATTEMPTS:  cfg_q.max_start_attempts <= pwdata[CNT_W-1:0];
          REG_SETTLE_POLLS:  cfg_q.settle_polls       <= pwdata[CNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Read mux.
  always_comb begin
    case (reg_idx)
      REG_LOW_THRESHOLD: prdata = APB_DW'(cfg_q.low_threshold);
      REG_TRANSIT_COUNT: prdata = APB_DW'(cfg_q.transit_count);
      REG_GEN_OK_THR:    prdata = APB_DW'(cfg_q.gen_ok_threshold);
      REG_MAINS_OK_THR:  prdata = APB_DW'(cfg_q.mains_ok_threshold);
      REG_GEN_OFF_THR:   prdata = APB_DW'(cfg_q.gen_off_threshold);
      REG_START_PERIOD:  prdata = APB_DW'(cfg_q.start_pulse_period);
      REG_MAX_ATTEMPTS:  prdata = APB_DW'(cfg_q.max_start_attempts);
      REG_SETTLE_POLLS:  prdata = APB_DW'(cfg_q.settle_polls);
      default:           prdata = '0;
    endcase
  end

  assign cfg_o                = cfg_q;
  assign evt_o.access         = wr_en;
  assign evt_o.period_written = per_wr_q;

endmodule

### sv/gmtc_mod_unit.sv
// Bit-serial remainder unit that resyncs the starter pulse phase after a period write.
module gmtc_mod_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [gmtc_pkg::CNT_W-1:0] dividend_i,
  input  logic [gmtc_pkg::CNT_W-1:0] divisor_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [gmtc_pkg::CNT_W-1:0] rem_o
);
  import gmtc_pkg::*;

  localparam int unsigned STEP_W = $clog2(CNT_W + 1);

  logic [STEP_W-1:0] cnt_q;
  logic [CNT_W-1:0]  num_q;
  logic [CNT_W-1:0]  div_q;
  logic [CNT_W-1:0]  rem_q;
  logic [CNT_W:0]    trial;
  logic [CNT_W-1:0]  rem_d;

  // One restoring step: bring down the next dividend bit and subtract if it fits.
  always_comb begin
    trial = {rem_q, num_q[CNT_W-1]};
    if (trial >= {1'b0, div_q}) begin
      rem_d = CNT_W'(trial - {1'b0, div_q});
    end else begin
      rem_d = trial[CNT_W-1:0];
    end
  end

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= STEP_W'(CNT_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // Operand and partial remainder registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      num_q <= {num_q[CNT_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign done_o = (cnt_q == STEP_W'(1));
  assign rem_o  = rem_d;

endmodule

### sv/gmtc_step.sv
// Next-state logic for one request: window counting, event selection and relay control.
module gmtc_step #(
  parameter int unsigned WINDOW_TICKS = gmtc_pkg::WINDOW_TICKS_DEF
) (
  input  gmtc_pkg::gmtc_item_t  item_i,
  input  gmtc_pkg::gmtc_cfg_t   cfg_i,
  input  gmtc_pkg::gmtc_state_t state_i,
  output gmtc_pkg::gmtc_state_t state_o
);
  import gmtc_pkg::*;

  localparam logic [CNT_W-1:0] WIN_LEN = CNT_W'(WINDOW_TICKS);

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] count;
  } settle_t;

  // Inverter settle counter: advance and report when the target is reached.
  function automatic settle_t settle_step(input logic [CNT_W-1:0] cnt,
                                          input logic [CNT_W-1:0] polls);
    settle_t r;
    r.count = cnt + 1'b1;
    r.done  = (r.count >= polls);
    if (r.done) begin
      r.count = '0;
    end
    return r;
  endfunction

  gmtc_state_t                     s;
  logic [CHANNELS-1:0][VOLT_W-1:0] volt;
  logic [CHANNELS-1:0]             high;
  gmtc_event_e                     ev;
  settle_t                         st;
  logic [CNT_W-1:0]                per;
  logic [CNT_W-1:0]                mod_before;
  logic                            aborted;

  assign volt[0] = item_i.battery_voltage;
  assign volt[1] = item_i.mains_voltage;
  assign volt[2] = item_i.generator_voltage;

  always_comb begin
    s          = state_i;
    high       = '0;
    ev         = EV_ALL_LOW;
    st         = '0;
    per        = (cfg_i.start_pulse_period == '0) ? CNT_W'(1) : cfg_i.start_pulse_period;
    mod_before = state_i.pulse_mod;
    aborted    = 1'b0;

    if (item_i.mode) begin
      // Mode request only changes the start mode.
      s.auto_flag = item_i.auto_request;
    end else begin
      // Count low samples per channel, saturating.
      for (int i = 0; i < CHANNELS; i++) begin
        if (volt[i] < cfg_i.low_threshold && s.low_counts[i] != LOW_SAT) begin
          s.low_counts[i] = s.low_counts[i] + 1'b1;
        end
      end
      s.window_ticks = s.window_ticks + 1'b1;

      if (s.window_ticks >= WIN_LEN) begin
        s.window_ticks = '0;
        // Battery lands in the top event bit, generator in the bottom one.
        for (int i = 0; i < CHANNELS; i++) begin
          high[CHANNELS-1-i] = (s.low_counts[i] < cfg_i.transit_count);
        end
        ev = gmtc_event_e'(high);
        s.condition_code = CODE_NONE;

        case (ev)
          EV_ALL_LOW, EV_BAT_ONLY: begin
            s.relay_bits[RLY_INV]  = 1'b0;
            s.relay_bits[RLY_STOP] = 1'b0;
            s.relay_bits[RLY_CHG]  = 1'b0;
            // Generator start sequence.
            if (s.auto_flag) begin
              s.start_count = s.start_count + 1'b1;
              if (mod_before == '0) begin
                s.starter_phase         = !s.starter_phase;
                s.relay_bits[RLY_START] = s.starter_phase;
              end
              if (s.start_count == '0 || (mod_before + 1'b1) == per) begin
                s.pulse_mod = '0;
              end else begin
                s.pulse_mod = mod_before + 1'b1;
              end
              if (s.start_count > cfg_i.max_start_attempts) begin
                // Too many tries: give up and fall back to manual mode.
                s.starter_phase         = 1'b0;
                s.start_count           = '0;
                s.pulse_mod             = '0;
                s.auto_flag             = 1'b0;
                s.relay_bits[RLY_START] = 1'b0;
                s.condition_code        = CODE_START_FAILED;
                aborted                 = 1'b1;
              end
            end else begin
              s.starter_phase = 1'b0;
              s.start_count   = '0;
              s.pulse_mod     = '0;
            end
            if (!aborted) begin
              if (item_i.generator_voltage >= cfg_i.gen_ok_threshold) begin
                if (s.start_count != '0) begin
                  s.starter_phase = 1'b0;
                  s.start_count   = '0;
                  s.pulse_mod     = '0;
                end
                s.relay_bits[RLY_CHANGE] = 1'b1;
                s.relay_bits[RLY_START]  = 1'b0;
                st                       = settle_step(s.settle_count, cfg_i.settle_polls);
                s.settle_count           = st.count;
                if (st.done) begin
                  s.relay_bits[RLY_INV] = 1'b1;
                end
                s.condition_code = CODE_GEN_RUNNING;
              end else begin
                s.condition_code = CODE_GEN_STARTING;
              end
            end
          end

          EV_GEN_ONLY, EV_BAT_GEN: begin
            s.relay_bits[RLY_START] = 1'b0;
            s.relay_bits[RLY_STOP]  = 1'b0;
            if (ev == EV_BAT_GEN) begin
              s.relay_bits[RLY_CHG] = 1'b0;
            end
            s.relay_bits[RLY_CHANGE] = 1'b1;
            if (item_i.generator_voltage >= cfg_i.gen_ok_threshold) begin
              st             = settle_step(s.settle_count, cfg_i.settle_polls);
              s.settle_count = st.count;
              if (st.done) begin
                s.relay_bits[RLY_INV] = 1'b1;
              end
              s.condition_code = CODE_GEN_OK;
            end else begin
              s.condition_code = CODE_GEN_LOW;
            end
          end

          EV_MAINS_ONLY, EV_BAT_MAINS: begin
            s.relay_bits[RLY_START] = 1'b0;
            s.relay_bits[RLY_STOP]  = 1'b1;
            if (ev == EV_BAT_MAINS) begin
              s.relay_bits[RLY_CHG] = 1'b0;
            end
            s.relay_bits[RLY_CHANGE] = 1'b0;
            if (item_i.mains_voltage >= cfg_i.mains_ok_threshold) begin
              s.condition_code = CODE_MAINS_OK;
              st               = settle_step(s.settle_count, cfg_i.settle_polls);
              s.settle_count   = st.count;
              if (st.done) begin
                s.relay_bits[RLY_INV] = 1'b1;
              end
            end else begin
              s.condition_code = CODE_MAINS_LOW;
            end
          end

          default: begin
            // Mains and generator both high: stop the generator, stay on mains.
            s.relay_bits[RLY_INV]   = 1'b0;
            s.relay_bits[RLY_START] = 1'b0;
            s.relay_bits[RLY_STOP]  = 1'b1;
            if (ev == EV_ALL_HIGH) begin
              s.relay_bits[RLY_CHG] = 1'b0;
            end
            if (item_i.generator_voltage < cfg_i.gen_off_threshold) begin
              s.relay_bits[RLY_CHANGE] = 1'b0;
              s.condition_code         = CODE_GEN_OFF;
              if (ev == EV_MAINS_GEN) begin
                st             = settle_step(s.settle_count, cfg_i.settle_polls);
                s.settle_count = st.count;
                if (st.done) begin
                  s.relay_bits[RLY_INV] = 1'b1;
                end
              end
            end else begin
              s.condition_code = CODE_GEN_STILL_ON;
            end
            // The mains check may advance the settle counter a second time.
            if (item_i.mains_voltage >= cfg_i.mains_ok_threshold) begin
              s.condition_code = CODE_MAINS_OK;
              st               = settle_step(s.settle_count, cfg_i.settle_polls);
              s.settle_count   = st.count;
              if (st.done) begin
                s.relay_bits[RLY_INV] = 1'b1;
              end
            end else begin
              s.condition_code = CODE_MAINS_LOW;
            end
          end
        endcase

        // Record the event and its remote permission flags.
        s.event_index   = ev;
        s.start_allowed = (ev == EV_ALL_LOW) || (ev == EV_BAT_ONLY);
        s.stop_allowed  = (ev == EV_MAINS_GEN) || (ev == EV_ALL_HIGH);
        s.low_counts    = '0;
      end
    end

    state_o = s;
  end

endmodule

### sv/generator_mains_transfer_controller_core.sv
// Top level of the generator/mains transfer controller.
//
//   Port        Dir   Flow control       Carries
//   in_i        in    valid / ready      one tick of three voltages, or a mode request
//   out_o       out   valid / ready      relay states, event, code and flags after it
//   APB         in    psel/penable/...   eight configuration registers
//
// Each request passes through the input register and then the result register,
// and a new request is taken every cycle while results are drained and no
// configuration write or pulse phase resync holds in_i.ready low.
// A write to the start pulse period starts a bit-serial remainder unit; in_i.ready
// stays low during its access phase, while the write is flagged and while the unit
// is busy; any other write holds it low during its access phase.
// A stalled result keeps its register; the input register then waits behind it.
// Reset (rst_ni low) brings up automatic start mode with all relays off.
module generator_mains_transfer_controller_core #(
  parameter int unsigned WINDOW_TICKS = gmtc_pkg::WINDOW_TICKS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  gmtc_in_if.sink                     in_i,
  gmtc_out_if.source                  out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gmtc_pkg::APB_AW-1:0] paddr,
  input  logic [gmtc_pkg::APB_DW-1:0] pwdata,
  output logic [gmtc_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import gmtc_pkg::*;

  gmtc_cfg_t     cfg;
  gmtc_cfg_evt_t cfg_evt;

  logic          s1_valid_q;
  gmtc_item_t    s1_item_q;
  gmtc_item_t    in_item;
  gmtc_state_t   state_q;
  gmtc_state_t   state_d;
  gmtc_state_t   state_rst;
  gmtc_state_t   step_state;
  logic          out_valid_q;
  gmtc_result_t  res_q;
  gmtc_result_t  res_d;
  logic          advance;
  logic          in_accept;

  logic             mod_busy;
  logic             mod_done;
  logic [CNT_W-1:0] mod_rem;
  logic [CNT_W-1:0] per_eff;

  // Configuration registers.
  gmtc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg),
    .evt_o   (cfg_evt)
  );

  // Pulse phase resync after the period changes.
  assign per_eff = (cfg.start_pulse_period == '0) ? CNT_W'(1) : cfg.start_pulse_period;

  gmtc_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cfg_evt.period_written),
    .dividend_i (state_q.start_count),
    .divisor_i  (per_eff),
    .busy_o     (mod_busy),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // Handshake: the input register moves on whenever the result register is free.
  assign advance   = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !cfg_evt.access && !cfg_evt.period_written && !mod_busy &&
                      (!s1_valid_q || advance);
  assign in_accept = in_i.valid && in_i.ready;

  assign in_item.mode              = in_i.mode;
  assign in_item.battery_voltage   = in_i.battery_voltage;
  assign in_item.mains_voltage     = in_i.mains_voltage;
  assign in_item.generator_voltage = in_i.generator_voltage;
  assign in_item.auto_request      = in_i.auto_request;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= in_item;
    end
  end

  // Per-request next state.
  gmtc_step #(
    .WINDOW_TICKS (WINDOW_TICKS)
  ) u_step (
    .item_i  (s1_item_q),
    .cfg_i   (cfg),
    .state_i (state_q),
    .state_o (step_state)
  );

  // State update from a request, or from the resync unit when it finishes.
  always_comb begin
    state_d = state_q;
    if (advance) begin
      state_d = step_state;
    end else if (mod_done) begin
      state_d.pulse_mod = mod_rem;
    end
  end

  // Reset state: automatic mode, no condition code, everything else cleared.
  always_comb begin
    state_rst                = '0;
    state_rst.auto_flag      = 1'b1;
    state_rst.condition_code = CODE_NONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= state_rst;
    end else begin
      state_q <= state_d;
    end
  end

  // Result fields from the state after the request.
  always_comb begin
    res_d.inverter_relay   = step_state.relay_bits[RLY_INV];
    res_d.stop_relay       = step_state.relay_bits[RLY_STOP];
    res_d.charge_enable    = step_state.relay_bits[RLY_CHG];
    res_d.starter_drive    = step_state.relay_bits[RLY_START];
    res_d.changeover_relay = step_state.relay_bits[RLY_CHANGE];
    res_d.event_index      = step_state.event_index;
    res_d.condition_code   = step_state.condition_code;
    res_d.start_allowed    = step_state.start_allowed;
    res_d.stop_allowed     = step_state.stop_allowed;
    res_d.auto_start       = step_state.auto_flag;
    res_d.fast_blink       = (step_state.condition_code == CODE_GEN_STARTING) ||
                             (step_state.condition_code == CODE_START_FAILED) ||
                             (step_state.condition_code == CODE_GEN_LOW)      ||
                             (step_state.condition_code == CODE_MAINS_LOW)    ||
                             (step_state.condition_code == CODE_GEN_STILL_ON);
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.inverter_relay   = res_q.inverter_relay;
  assign out_o.stop_relay       = res_q.stop_relay;
  assign out_o.charge_enable    = res_q.charge_enable;
  assign out_o.starter_drive    = res_q.starter_drive;
  assign out_o.changeover_relay = res_q.changeover_relay;
  assign out_o.event_index      = res_q.event_index;
  assign out_o.condition_code   = res_q.condition_code;
  assign out_o.start_allowed    = res_q.start_allowed;
  assign out_o.stop_allowed     = res_q.stop_allowed;
  assign out_o.auto_start       = res_q.auto_start;
  assign out_o.fast_blink       = res_q.fast_blink;

  // The pulse phase tracks the start counter: a cleared counter has phase zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.start_count == '0) |-> (state_q.pulse_mod == '0))
    else $error("pulse phase out of step with start counter");

  // The window counter never reaches the window length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.window_ticks < CNT_W'(WINDOW_TICKS))
    else $error("window tick counter overran the window");

  // No request is taken while the pulse phase is being recomputed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_busy |-> !in_i.ready)
    else $error("request accepted during pulse phase resync");

  // A request leaving the input register always shows up as a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result lost after input register advanced");

endmodule

### bench/generator_mains_transfer_controller_core_tb.sv
// Self-checking testbench for the generator/mains transfer controller core.
module generator_mains_transfer_controller_core_tb;
  import gmtc_pkg::*;

  localparam int unsigned WINDOW = WINDOW_TICKS_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // Tracks the controller state from accepted requests and checks each status word.
  class transfer_checker;
    gmtc_cfg_t          cfg;
    logic [CNT_W-1:0]   ticks;
    logic [CNT_W-1:0]   low_cnt [CHANNELS];
    logic [CNT_W-1:0]   start_cnt;
    logic               starter_on;
    logic [CNT_W-1:0]   settle_cnt;
    logic               auto_on;
    logic [RELAY_W-1:0] relays;
    gmtc_event_e        last_event;
    logic [CODE_W-1:0]  code;
    logic               start_ok;
    logic               stop_ok;
    gmtc_result_t       expected_status [$];
    int unsigned        mismatches;

    function new();
      cfg.low_threshold      = 16'd1200;
      cfg.transit_count      = 8'd5;
      cfg.gen_ok_threshold   = 16'd20000;
      cfg.mains_ok_threshold = 16'd20000;
      cfg.gen_off_threshold  = 16'd5000;
      cfg.start_pulse_period = 8'd2;
      cfg.max_start_attempts = 8'd6;
      cfg.settle_polls       = 8'd5;
      ticks = '0;
      foreach (low_cnt[ch]) low_cnt[ch] = '0;
      start_cnt  = '0;
      starter_on = 1'b0;
      settle_cnt = '0;
      auto_on    = 1'b1;
      relays     = '0;
      last_event = EV_ALL_LOW;
      code       = CODE_NONE;
      start_ok   = 1'b0;
      stop_ok    = 1'b0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return expected_status.size();
    endfunction

    // Register writes keep only the low bits of the register's width.
    function void set_register(gmtc_reg_e idx, logic [APB_DW-1:0] word);
      case (idx)
        REG_LOW_THRESHOLD: cfg.low_threshold      = word[15:0];
        REG_TRANSIT_COUNT: cfg.transit_count      = word[7:0];
        REG_GEN_OK_THR:    cfg.gen_ok_threshold   = word[15:0];
        REG_MAINS_OK_THR:  cfg.mains_ok_threshold = word[15:0];
        REG_GEN_OFF_THR:   cfg.gen_off_threshold  = word[15:0];
        REG_START_PERIOD:  cfg.start_pulse_period = word[7:0];
        REG_MAX_ATTEMPTS:  cfg.max_start_attempts = word[7:0];
        default:           cfg.settle_polls       = word[7:0];
      endcase
    endfunction

    // Inverter settle counter; reports when the target has been reached.
    function bit settle_elapsed();
      settle_cnt = settle_cnt + 8'd1;
      if (settle_cnt >= cfg.settle_polls) begin
        settle_cnt = '0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // Generator start sequence: starter toggling, attempt limit and fallback to manual.
    function void crank_generator(logic [VOLT_W-1:0] gen);
      logic [CNT_W-1:0] per;
      logic [CNT_W-1:0] prior;
      if (auto_on) begin
        per = (cfg.start_pulse_period == '0) ? 8'd1 : cfg.start_pulse_period;
        prior = start_cnt;
        start_cnt = start_cnt + 8'd1;
        if (prior % per == '0) begin
          starter_on = ~starter_on;
          relays[RLY_START] = starter_on;
        end
        if (start_cnt > cfg.max_start_attempts) begin
          starter_on = 1'b0;
          start_cnt = '0;
          auto_on = 1'b0;
          relays[RLY_START] = 1'b0;
          code = CODE_START_FAILED;
          return;
        end
      end else begin
        starter_on = 1'b0;
        start_cnt = '0;
      end
      if (gen >= cfg.gen_ok_threshold) begin
        if (start_cnt != '0) begin
          starter_on = 1'b0;
          start_cnt = '0;
        end
        relays[RLY_CHANGE] = 1'b1;
        relays[RLY_START] = 1'b0;
        if (settle_elapsed()) relays[RLY_INV] = 1'b1;
        code = CODE_GEN_RUNNING;
      end else begin
        code = CODE_GEN_STARTING;
      end
    endfunction

    function void check_mains(logic [VOLT_W-1:0] mains);
      if (mains >= cfg.mains_ok_threshold) begin
        code = CODE_MAINS_OK;
        if (settle_elapsed()) relays[RLY_INV] = 1'b1;
      end else begin
        code = CODE_MAINS_LOW;
      end
    endfunction

    function void check_generator(logic [VOLT_W-1:0] gen);
      if (gen >= cfg.gen_ok_threshold) begin
        if (settle_elapsed()) relays[RLY_INV] = 1'b1;
        code = CODE_GEN_OK;
      end else begin
        code = CODE_GEN_LOW;
      end
    endfunction

    // Relay actions and status of the event picked at a window end.
    function void run_event(gmtc_event_e ev, logic [VOLT_W-1:0] mains,
                            logic [VOLT_W-1:0] gen);
      code = CODE_NONE;
      case (ev)
        EV_ALL_LOW, EV_BAT_ONLY: begin
          relays[RLY_INV] = 1'b0;
          relays[RLY_STOP] = 1'b0;
          relays[RLY_CHG] = 1'b0;
          crank_generator(gen);
        end
        EV_GEN_ONLY, EV_BAT_GEN: begin
          relays[RLY_START] = 1'b0;
          relays[RLY_STOP] = 1'b0;
          if (ev == EV_BAT_GEN) relays[RLY_CHG] = 1'b0;
          relays[RLY_CHANGE] = 1'b1;
          check_generator(gen);
        end
        EV_MAINS_ONLY, EV_BAT_MAINS: begin
          relays[RLY_START] = 1'b0;
          relays[RLY_STOP] = 1'b1;
          if (ev == EV_BAT_MAINS) relays[RLY_CHG] = 1'b0;
          relays[RLY_CHANGE] = 1'b0;
          check_mains(mains);
        end
        default: begin
          relays[RLY_INV] = 1'b0;
          relays[RLY_START] = 1'b0;
          relays[RLY_STOP] = 1'b1;
          if (ev == EV_ALL_HIGH) relays[RLY_CHG] = 1'b0;
          if (gen < cfg.gen_off_threshold) begin
            relays[RLY_CHANGE] = 1'b0;
            code = CODE_GEN_OFF;
            if (ev == EV_MAINS_GEN) begin
              if (settle_elapsed()) relays[RLY_INV] = 1'b1;
            end
          end else begin
            code = CODE_GEN_STILL_ON;
          end
          check_mains(mains);
        end
      endcase
      last_event = ev;
      start_ok = (ev == EV_ALL_LOW) || (ev == EV_BAT_ONLY);
      stop_ok = (ev == EV_MAINS_GEN) || (ev == EV_ALL_HIGH);
    endfunction

    // Advances the state by one accepted request and queues the status it leads to.
    function void take_request(gmtc_item_t it);
      gmtc_result_t     r;
      logic [VOLT_W-1:0] volts [CHANNELS];
      logic [EVENT_W-1:0] sel;
      sel = '0;
      if (it.mode) begin
        auto_on = it.auto_request;
      end else begin
        volts[0] = it.battery_voltage;
        volts[1] = it.mains_voltage;
        volts[2] = it.generator_voltage;
        for (int ch = 0; ch < CHANNELS; ch++)
          if (volts[ch] < cfg.low_threshold && low_cnt[ch] != LOW_SAT)
            low_cnt[ch] = low_cnt[ch] + 8'd1;
        ticks = ticks + 8'd1;
        if (ticks >= WINDOW) begin
          ticks = '0;
          for (int ch = 0; ch < CHANNELS; ch++)
            sel = {sel[EVENT_W-2:0], low_cnt[ch] < cfg.transit_count};
          run_event(gmtc_event_e'(sel), volts[1], volts[2]);
          for (int ch = 0; ch < CHANNELS; ch++) low_cnt[ch] = '0;
        end
      end
      r.inverter_relay   = relays[RLY_INV];
      r.stop_relay       = relays[RLY_STOP];
      r.charge_enable    = relays[RLY_CHG];
      r.starter_drive    = relays[RLY_START];
      r.changeover_relay = relays[RLY_CHANGE];
      r.event_index      = last_event;
      r.condition_code   = code;
      r.start_allowed    = start_ok;
      r.stop_allowed     = stop_ok;
      r.auto_start       = auto_on;
      r.fast_blink       = (code == CODE_GEN_STARTING) || (code == CODE_START_FAILED) ||
                           (code == CODE_GEN_LOW) || (code == CODE_MAINS_LOW) ||
                           (code == CODE_GEN_STILL_ON);
      expected_status.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    // Compares one returned status word with the oldest outstanding one.
    function void check_status(gmtc_result_t got);
      gmtc_result_t want;
      if (expected_status.size() == 0) begin
        $display("%0t: status returned with no request outstanding, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = expected_status.pop_front();
      compare_field("inverter_relay", want.inverter_relay, got.inverter_relay);
      compare_field("stop_relay", want.stop_relay, got.stop_relay);
      compare_field("charge_enable", want.charge_enable, got.charge_enable);
      compare_field("starter_drive", want.starter_drive, got.starter_drive);
      compare_field("changeover_relay", want.changeover_relay, got.changeover_relay);
      compare_field("event_index", want.event_index, got.event_index);
      compare_field("condition_code", want.condition_code, got.condition_code);
      compare_field("start_allowed", want.start_allowed, got.start_allowed);
      compare_field("stop_allowed", want.stop_allowed, got.stop_allowed);
      compare_field("auto_start", want.auto_start, got.auto_start);
      compare_field("fast_blink", want.fast_blink, got.fast_blink);
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [APB_AW-1:0]  paddr;
  logic [APB_DW-1:0]  pwdata;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  gmtc_in_if  req_if ();
  gmtc_out_if rsp_if ();

  generator_mains_transfer_controller_core #(
    .WINDOW_TICKS(WINDOW)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (req_if),
    .out_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  transfer_checker sb;
  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned cycles;
  int unsigned plan_low [CHANNELS];
  int unsigned plan_rot [CHANNELS];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Cycle budget for the whole run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("generator_mains_transfer_controller_core regression: fail");
      $finish;
    end
  end

  // Receiver stalls at random.
  always @(negedge clk_i) begin
    rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Every status word taken by the receiver is checked.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready)
      sb.check_status('{inverter_relay:   rsp_if.inverter_relay,
                        stop_relay:       rsp_if.stop_relay,
                        charge_enable:    rsp_if.charge_enable,
                        starter_drive:    rsp_if.starter_drive,
                        changeover_relay: rsp_if.changeover_relay,
                        event_index:      rsp_if.event_index,
                        condition_code:   rsp_if.condition_code,
                        start_allowed:    rsp_if.start_allowed,
                        stop_allowed:     rsp_if.stop_allowed,
                        auto_start:       rsp_if.auto_start,
                        fast_blink:       rsp_if.fast_blink});
  end

  function automatic gmtc_item_t make_item(logic mode, logic [15:0] bat, logic [15:0] mains,
                                           logic [15:0] gen, logic auto_req);
    gmtc_item_t it;
    it.mode              = mode;
    it.battery_voltage   = bat;
    it.mains_voltage     = mains;
    it.generator_voltage = gen;
    it.auto_request      = auto_req;
    return it;
  endfunction

  // A sample below the low threshold when asked for, otherwise at or above it.
  function automatic logic [15:0] level_for(bit want_low);
    int unsigned thr;
    thr = sb.cfg.low_threshold;
    if (want_low && thr != 0) return 16'($urandom_range(0, thr - 1));
    return 16'($urandom_range(thr, 16'hFFFF));
  endfunction

  // A value at or just under one of two thresholds, an extreme, or a random value.
  function automatic logic [15:0] near_threshold(logic [15:0] a, logic [15:0] b);
    case ($urandom_range(0, 5))
      0: return a - 16'd1;
      1: return a;
      2: return b - 16'd1;
      3: return b;
      4: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Next sample tick; at each window start a target event is chosen and the
  // low-sample counts are placed around the transit count to reach it.
  function automatic gmtc_item_t next_tick();
    int unsigned       pos;
    int unsigned       tr;
    logic [EVENT_W-1:0] ev;
    logic [15:0]       v [CHANNELS];
    pos = sb.ticks;
    tr = sb.cfg.transit_count;
    if (pos == 0) begin
      if ($urandom_range(0, 99) < 40)
        ev = $urandom_range(0, 1) ? 3'(EV_BAT_ONLY) : 3'(EV_ALL_LOW);
      else
        ev = 3'($urandom);
      for (int ch = 0; ch < CHANNELS; ch++) begin
        if (ev[2 - ch])
          plan_low[ch] = (tr == 0) ? 0 : $urandom_range(0, (tr - 1 > WINDOW) ? WINDOW : tr - 1);
        else
          plan_low[ch] = (tr > WINDOW) ? WINDOW : $urandom_range(tr, WINDOW);
        plan_rot[ch] = $urandom_range(0, WINDOW - 1);
      end
    end
    for (int ch = 0; ch < CHANNELS; ch++)
      v[ch] = level_for(((pos + plan_rot[ch]) % WINDOW) < plan_low[ch]);
    // The last tick's mains and generator values drive the event checks.
    if (pos == WINDOW - 1 && $urandom_range(0, 1)) begin
      v[1] = near_threshold(sb.cfg.mains_ok_threshold, sb.cfg.low_threshold);
      v[2] = near_threshold(sb.cfg.gen_ok_threshold, sb.cfg.gen_off_threshold);
    end
    if ($urandom_range(0, 9) == 0)
      for (int ch = 0; ch < CHANNELS; ch++) v[ch] = 16'($urandom);
    return make_item(1'b0, v[0], v[1], v[2], 1'($urandom));
  endfunction

  function automatic gmtc_item_t next_random();
    if ($urandom_range(0, 99) < 8)
      return make_item(1'b1, 16'($urandom), 16'($urandom), 16'($urandom),
                       $urandom_range(0, 3) != 0);
    return next_tick();
  endfunction

  // Sends one request after a random gap and waits until it is taken.
  task automatic push_request(gmtc_item_t it);
    int unsigned gap;
    gap = 0;
    while (gap < 24 && $urandom_range(0, 99) < gap_pct) gap++;
    repeat (gap) begin
      @(negedge clk_i);
      req_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    req_if.valid             <= 1'b1;
    req_if.mode              <= it.mode;
    req_if.battery_voltage   <= it.battery_voltage;
    req_if.mains_voltage     <= it.mains_voltage;
    req_if.generator_voltage <= it.generator_voltage;
    req_if.auto_request      <= it.auto_request;
    do @(posedge clk_i); while (!req_if.ready);
    sb.take_request(it);
  endtask

  // Stops sending and waits until every outstanding status has come back.
  task automatic drain();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // One configuration write; the bits above the register width carry noise at times.
  task automatic write_register(gmtc_reg_e idx, logic [15:0] value);
    logic [APB_DW-1:0] word;
    word = $urandom_range(0, 1) ? $urandom : '0;
    case (idx)
      REG_TRANSIT_COUNT, REG_START_PERIOD, REG_MAX_ATTEMPTS, REG_SETTLE_POLLS:
        word[7:0] = value[7:0];
      default:
        word[15:0] = value;
    endcase
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_register(idx, word);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_all(logic [15:0] vals [8]);
    for (int i = 0; i < 8; i++) write_register(gmtc_reg_e'(i), vals[i]);
  endtask

  // Register settings per phase: zero period and settle, all minimums,
  // all maximums, then random values.
  task automatic apply_settings(int unsigned which);
    logic [15:0] vals [8];
    case (which)
      0: vals = '{16'd1200, 16'd5, 16'd20000, 16'd20000, 16'd5000, 16'd0, 16'd4, 16'd0};
      1: vals = '{16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 16'd1};
      2: vals = '{16'hFFFF, 16'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd255, 16'd255, 16'd255};
      default: begin
        vals[REG_LOW_THRESHOLD] = 16'($urandom_range(300, 40000));
        vals[REG_TRANSIT_COUNT] = 16'($urandom_range(0, 11));
        vals[REG_GEN_OK_THR]    = 16'($urandom);
        vals[REG_MAINS_OK_THR]  = 16'($urandom);
        vals[REG_GEN_OFF_THR]   = 16'($urandom);
        vals[REG_START_PERIOD]  = 16'($urandom_range(0, 4));
        vals[REG_MAX_ATTEMPTS]  = 16'($urandom_range(0, 9));
        vals[REG_SETTLE_POLLS]  = 16'($urandom_range(0, 6));
      end
    endcase
    write_all(vals);
  endtask

  task automatic set_idling(int unsigned sel);
    case (sel)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 72; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 72; end
      default: begin gap_pct = 16; stall_pct = 16; end
    endcase
  endtask

  initial begin
    sb = new();
    cycles = 0;
    gap_pct = 0;
    stall_pct = 0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_if.valid = 1'b0;
    req_if.mode = 1'b0;
    req_if.battery_voltage = '0;
    req_if.mains_voltage = '0;
    req_if.generator_voltage = '0;
    req_if.auto_request = 1'b0;
    rsp_if.ready = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: mode requests ignore their voltages; a manual-mode start window;
    // back to auto, then a window with battery and generator high.
    push_request(make_item(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
    repeat (WINDOW) push_request(make_item(1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    push_request(make_item(1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b1));
    repeat (WINDOW) push_request(make_item(1'b0, 16'hFFFF, 16'h0000, 16'hAAAA, 1'b1));
    push_request(make_item(1'b0, 16'h5555, 16'hAAAA, 16'h5555, 1'b0));
    push_request(make_item(1'b0, 16'h8000, 16'h7FFF, 16'h0001, 1'b1));

    // Random phases, each with its own settings and idling.
    for (int unsigned p = 0; p < 8; p++) begin
      drain();
      apply_settings(p);
      set_idling(p % 4);
      repeat (88) push_request(next_random());
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0)
      $display("generator_mains_transfer_controller_core regression: pass");
    else
      $display("generator_mains_transfer_controller_core regression: fail");
    $finish;
  end

endmodule
